// ===== rtl/frb_pkg.sv =====
// ----------------------------------------------------------------------------
// frb_pkg: shared types and constants for the fault recovery tracker
// Event, result and configuration payloads, register indexes, reset values.
// ----------------------------------------------------------------------------
package frb_pkg;

	localparam int unsigned KindW   = 2;
	localparam int unsigned TickW   = 32;
	localparam int unsigned StreakW = 16;
	localparam int unsigned CountW  = 32;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDatW = 32;

	localparam logic [TickW-1:0]   InitialDelayRst = TickW'(100);
	localparam logic [TickW-1:0]   MaxDelayRst     = TickW'(5000);
	localparam logic [StreakW-1:0] ThresholdRst    = StreakW'(3);

	typedef enum logic [KindW-1:0] {
		KIND_INITIAL = 2'd0,
		KIND_SERVICE = 2'd1,
		KIND_REINIT  = 2'd2,
		KIND_POLL    = 2'd3
	} kind_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_INITIAL_DELAY = 2'd0,
		REG_MAX_DELAY     = 2'd1,
		REG_THRESHOLD     = 2'd2,
		REG_UNUSED        = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [KindW-1:0] kind;
		logic [TickW-1:0] now;
		logic             succeeded;
	} evt_t;

	typedef struct packed {
		logic               went_offline;
		logic               retry_due;
		logic               retry_pending;
		logic [TickW-1:0]   delay_now;
		logic [StreakW-1:0] failure_streak;
		logic [CountW-1:0]  offline_count;
		logic [CountW-1:0]  attempt_count;
		logic [CountW-1:0]  success_count;
	} res_t;

	typedef struct packed {
		logic [CfgIdxW-1:0] index;
		logic [CfgDatW-1:0] data;
	} cfg_t;

endpackage

// ===== rtl/frb_if.sv =====
// ----------------------------------------------------------------------------
// frb_if: valid/ready channels of the fault recovery tracker
// Event, result and configuration write channels.
// ----------------------------------------------------------------------------
interface frb_evt_if;
	import frb_pkg::*;
	logic valid;
	logic ready;
	evt_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface frb_res_if;
	import frb_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface frb_cfg_if;
	import frb_pkg::*;
	logic valid;
	logic ready;
	cfg_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/fault_recovery_backoff_top.sv =====
// ----------------------------------------------------------------------------
// fault_recovery_backoff_top: device fault recovery tracker
// Counts service failures, declares the device offline and paces
// reinitialization retries with a doubling, clamped delay.
// ----------------------------------------------------------------------------
// Usage:
//   evt  - one beat per event: kind, millisecond tick, success flag.
//   res  - one status beat per event, in event order, taken after the
//          event has updated the tracker state.
//   cfg  - register writes (index, data); always ready. Write only while
//          no event is in flight.
// The event is first registered in the event register; the state update and
// status are then worked out in one pass and land in the result register.
// One event per cycle is sustained while res is not stalled, since each
// event depends on the previous one only through the state registers that
// the single pass updates.
// When res stalls, the event register holds one more event and then evt
// ready drops; nothing is lost or repeated.
// Reset clears all counters, the pending retry and the delay, and loads
// the registers with 100 ms initial delay, 5000 ms maximum, threshold 3.
// ----------------------------------------------------------------------------
module fault_recovery_backoff_top (
	input  logic clk,
	input  logic arst_n,
	frb_evt_if.sink   evt,
	frb_res_if.source res,
	frb_cfg_if.sink   cfg
);
	import frb_pkg::*;

	// configuration
	logic [TickW-1:0]   initial_delay_q;
	logic [TickW-1:0]   max_delay_q;
	logic [StreakW-1:0] threshold_q;

	// tracker state
	logic [TickW-1:0]   retry_start_q;
	logic [TickW-1:0]   retry_delay_q;
	logic               pending_q;
	logic [StreakW-1:0] fail_streak_q;
	logic [CountW-1:0]  offline_events_q;
	logic [CountW-1:0]  attempts_q;
	logic [CountW-1:0]  successes_q;

	// pipeline
	logic valid_s1;
	evt_t evt_s1;
	logic valid_s2;
	res_t res_s2;
	logic advance;

	// next state
	logic [TickW-1:0]   start_nx;
	logic [TickW-1:0]   delay_nx;
	logic               pending_nx;
	logic [StreakW-1:0] streak_nx;
	logic [CountW-1:0]  offline_nx;
	logic [CountW-1:0]  attempts_nx;
	logic [CountW-1:0]  successes_nx;
	logic               offline_now;
	logic [StreakW-1:0] streak_inc;
	logic [TickW:0]     twice;
	logic [TickW-1:0]   backoff;
	logic [TickW-1:0]   elapsed;
	res_t               res_nx;

	assign cfg.ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign evt.ready = !valid_s1 || advance;
	assign res.valid = valid_s2;
	assign res.data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_delay_q <= InitialDelayRst;
			max_delay_q     <= MaxDelayRst;
			threshold_q     <= ThresholdRst;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.data.index))
				REG_INITIAL_DELAY: initial_delay_q <= cfg.data.data;
				REG_MAX_DELAY:     max_delay_q     <= cfg.data.data;
				REG_THRESHOLD:     threshold_q     <= cfg.data.data[StreakW-1:0];
				default: ;
			endcase
		end
	end

	// next delay after a failed reinit; doubled in 33 bits so it cannot wrap
	always_comb begin
		twice = {retry_delay_q, 1'b0};
		if (retry_delay_q < initial_delay_q) begin
			backoff = initial_delay_q;
		end else if (retry_delay_q < max_delay_q) begin
			backoff = (twice > {1'b0, max_delay_q}) ? max_delay_q : twice[TickW-1:0];
		end else begin
			backoff = retry_delay_q;
		end
	end

	always_comb begin
		start_nx     = retry_start_q;
		delay_nx     = retry_delay_q;
		pending_nx   = pending_q;
		streak_nx    = fail_streak_q;
		offline_nx   = offline_events_q;
		attempts_nx  = attempts_q;
		successes_nx = successes_q;
		offline_now  = 1'b0;
		streak_inc   = (fail_streak_q == '1) ? fail_streak_q : fail_streak_q + 1'b1;
		case (kind_t'(evt_s1.kind))
			KIND_INITIAL: begin
				streak_nx = '0;
				if (evt_s1.succeeded) begin
					pending_nx = 1'b0;
					delay_nx   = '0;
				end else begin
					offline_nx = offline_events_q + 1'b1;
					start_nx   = evt_s1.now;
					delay_nx   = initial_delay_q;
					pending_nx = 1'b1;
				end
			end
			KIND_SERVICE: begin
				if (evt_s1.succeeded) begin
					streak_nx = '0;
				end else begin
					streak_nx = streak_inc;
					if (!pending_q && streak_inc >= threshold_q) begin
						offline_nx  = offline_events_q + 1'b1;
						start_nx    = evt_s1.now;
						delay_nx    = initial_delay_q;
						pending_nx  = 1'b1;
						offline_now = 1'b1;
					end
				end
			end
			KIND_REINIT: begin
				attempts_nx = attempts_q + 1'b1;
				if (evt_s1.succeeded) begin
					successes_nx = successes_q + 1'b1;
					streak_nx    = '0;
					pending_nx   = 1'b0;
					delay_nx     = '0;
				end else begin
					start_nx   = evt_s1.now;
					delay_nx   = backoff;
					pending_nx = 1'b1;
				end
			end
			default: ;
		endcase

		elapsed = evt_s1.now - start_nx;   // wraps with the tick

		res_nx.went_offline   = offline_now;
		res_nx.retry_due      = pending_nx && (elapsed >= delay_nx);
		res_nx.retry_pending  = pending_nx;
		res_nx.delay_now      = delay_nx;
		res_nx.failure_streak = streak_nx;
		res_nx.offline_count  = offline_nx;
		res_nx.attempt_count  = attempts_nx;
		res_nx.success_count  = successes_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			valid_s2         <= 1'b0;
			retry_start_q    <= '0;
			retry_delay_q    <= '0;
			pending_q        <= 1'b0;
			fail_streak_q    <= '0;
			offline_events_q <= '0;
			attempts_q       <= '0;
			successes_q      <= '0;
		end else begin
			if (evt.ready) begin
				valid_s1 <= evt.valid;
			end
			if (advance) begin
				valid_s2         <= 1'b1;
				retry_start_q    <= start_nx;
				retry_delay_q    <= delay_nx;
				pending_q        <= pending_nx;
				fail_streak_q    <= streak_nx;
				offline_events_q <= offline_nx;
				attempts_q       <= attempts_nx;
				successes_q      <= successes_nx;
			end else if (res.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			evt_s1 <= evt.data;
		end
		if (advance) begin
			res_s2 <= res_nx;
		end
	end

	// no pending retry means the delay was cleared with it
	a_idle_delay: assert property (@(posedge clk) disable iff (!arst_n)
		!pending_q |-> retry_delay_q == '0)
		else $error("delay non-zero with no retry pending");

	// an empty result register never holds back the event side
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> evt.ready)
		else $error("event channel stalled with empty result register");

	// going offline always leaves a retry scheduled and a failure counted
	a_offline_sched: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.went_offline |->
			res_s2.retry_pending && res_s2.failure_streak != '0)
		else $error("offline declared without a scheduled retry");

	// offline counter stays put while no event advances
	a_offline_step: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(offline_events_q))
		else $error("offline counter changed without an event");

	// a service failure never lowers the streak
	a_streak_mono: assert property (@(posedge clk) disable iff (!arst_n)
		advance && evt_s1.kind == KIND_SERVICE && !evt_s1.succeeded |=>
			fail_streak_q >= $past(fail_streak_q))
		else $error("failure streak fell on a service failure");

endmodule

// ===== verif/fault_recovery_backoff_chk.sv =====
// ----------------------------------------------------------------------------
// fault_recovery_backoff_chk: status predictor and scoreboard
// Watches the event, result and register channels. Keeps its own copy of the
// tracker state and registers, works out the status owed for each event beat
// and compares every result beat, field by field, with the oldest one owed.
// ----------------------------------------------------------------------------
module fault_recovery_backoff_chk (
	input  logic        clk,
	input  logic        arst_n,
	frb_evt_if          evt,
	frb_res_if          res,
	frb_cfg_if          cfg,
	output int unsigned mismatches,
	output int unsigned status_owed
);
	timeunit 1ns;
	timeprecision 1ps;
	import frb_pkg::*;

	logic [TickW-1:0]   init_r;
	logic [TickW-1:0]   max_r;
	logic [StreakW-1:0] thr_r;

	logic [TickW-1:0]   start_t;
	logic [TickW-1:0]   delay_t;
	logic               pend;
	logic [StreakW-1:0] streak;
	logic [CountW-1:0]  offl;
	logic [CountW-1:0]  tries;
	logic [CountW-1:0]  wins;

	res_t        owed_q[$];
	res_t        want;
	int unsigned errs = 0;

	function automatic void arm_retry(input logic [TickW-1:0] t, input logic [TickW-1:0] d);
		start_t = t;
		delay_t = d;
		pend    = 1'b1;
	endfunction

	function automatic res_t track_event(input evt_t e);
		res_t             st;
		logic [TickW-1:0] elapsed;
		logic [TickW-1:0] next;
		logic [TickW:0]   twice;
		logic             offline_now;
		offline_now = 1'b0;
		case (kind_t'(e.kind))
			KIND_INITIAL: begin
				streak = '0;
				if (e.succeeded) begin
					pend    = 1'b0;
					delay_t = '0;
				end else begin
					offl = offl + 1'b1;
					arm_retry(e.now, init_r);
				end
			end
			KIND_SERVICE: begin
				if (e.succeeded) begin
					streak = '0;
				end else begin
					if (streak != '1)
						streak = streak + 1'b1;
					if (!pend && streak >= thr_r) begin
						offl = offl + 1'b1;
						arm_retry(e.now, init_r);
						offline_now = 1'b1;
					end
				end
			end
			KIND_REINIT: begin
				tries = tries + 1'b1;
				if (e.succeeded) begin
					wins    = wins + 1'b1;
					streak  = '0;
					pend    = 1'b0;
					delay_t = '0;
				end else begin
					// doubling is done one bit wider so that it clamps rather than wraps
					if (delay_t < init_r) begin
						next = init_r;
					end else if (delay_t < max_r) begin
						twice = {delay_t, 1'b0};
						next  = (twice > {1'b0, max_r}) ? max_r : twice[TickW-1:0];
					end else begin
						next = delay_t;
					end
					arm_retry(e.now, next);
				end
			end
			default: begin
			end
		endcase
		elapsed           = e.now - start_t;
		st.went_offline   = offline_now;
		st.retry_due      = pend && (elapsed >= delay_t);
		st.retry_pending  = pend;
		st.delay_now      = delay_t;
		st.failure_streak = streak;
		st.offline_count  = offl;
		st.attempt_count  = tries;
		st.success_count  = wins;
		return st;
	endfunction

	function automatic int field_diff(input string name, input logic [31:0] w,
			input logic [31:0] got);
		if (w !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, w, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_r  = InitialDelayRst;
			max_r   = MaxDelayRst;
			thr_r   = ThresholdRst;
			start_t = '0;
			delay_t = '0;
			pend    = 1'b0;
			streak  = '0;
			offl    = '0;
			tries   = '0;
			wins    = '0;
			owed_q.delete();
			status_owed <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (reg_idx_t'(cfg.data.index))
					REG_INITIAL_DELAY: init_r = cfg.data.data;
					REG_MAX_DELAY:     max_r  = cfg.data.data;
					REG_THRESHOLD:     thr_r  = cfg.data.data[StreakW-1:0];
					default: begin
					end
				endcase
			end
			if (evt.valid && evt.ready)
				owed_q.push_back(track_event(evt.data));
			if (res.valid && res.ready) begin
				if (owed_q.size() == 0) begin
					$display("%0t: result beat with no status owed: %p", $time, res.data);
					errs++;
				end else begin
					want = owed_q.pop_front();
					errs += field_diff("went_offline", 32'(want.went_offline),
						32'(res.data.went_offline));
					errs += field_diff("retry_due", 32'(want.retry_due),
						32'(res.data.retry_due));
					errs += field_diff("retry_pending", 32'(want.retry_pending),
						32'(res.data.retry_pending));
					errs += field_diff("delay_now", want.delay_now, res.data.delay_now);
					errs += field_diff("failure_streak", 32'(want.failure_streak),
						32'(res.data.failure_streak));
					errs += field_diff("offline_count", want.offline_count,
						res.data.offline_count);
					errs += field_diff("attempt_count", want.attempt_count,
						res.data.attempt_count);
					errs += field_diff("success_count", want.success_count,
						res.data.success_count);
				end
			end
			status_owed <= owed_q.size();
		end
		mismatches <= errs;
	end

endmodule

// ===== verif/fault_recovery_backoff_top_tb.sv =====
// ----------------------------------------------------------------------------
// fault_recovery_backoff_top_tb: testbench top for the fault recovery tracker
// Drives event beats with random gaps, writes registers between runs, stalls the
// result channel at random. A directed run walks the backoff ladder across a
// tick wrap, then outage sequences with random content run under a range of
// register settings, including a long failure streak under an all-ones threshold.
// ----------------------------------------------------------------------------
module fault_recovery_backoff_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import frb_pkg::*;

	localparam int unsigned CycleLimit = 2_000_000;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned chk_mismatches;
	int unsigned chk_owed;
	int unsigned cycles = 0;

	logic [31:0] init_w;
	logic [31:0] max_w;
	logic [15:0] thr_w;
	logic [31:0] tick;
	logic [31:0] anchor;
	bit          quiet = 1'b0;
	int unsigned sent = 0;

	frb_evt_if evt_ch ();
	frb_res_if res_ch ();
	frb_cfg_if cfg_ch ();

	fault_recovery_backoff_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	fault_recovery_backoff_chk u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.evt         (evt_ch),
		.res         (res_ch),
		.cfg         (cfg_ch),
		.mismatches  (chk_mismatches),
		.status_owed (chk_owed)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	initial begin
		wait (cycles == CycleLimit);
		$display("tb: failure");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 10);
		return $urandom_range(11, 24);
	endfunction

	function automatic logic [31:0] thr_word(input logic [15:0] th);
		// upper half is junk: only the low 16 bits are the threshold
		return {16'($urandom), th};
	endfunction

	// result side: random runs of ready with stalls in between
	initial begin
		int unsigned run;
		int unsigned stall;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			res_ch.ready <= 1'b1;
			run = $urandom_range(1, 40);
			repeat (run) @(posedge clk);
			stall = quiet ? 0 : pick_gap();
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	task automatic post_event(input kind_t k, input logic [31:0] t, input logic ok);
		evt_t        e;
		int unsigned gap;
		e.kind      = k;
		e.now       = t;
		e.succeeded = ok;
		evt_ch.valid <= 1'b1;
		evt_ch.data  <= e;
		do @(posedge clk); while (!evt_ch.ready);
		sent++;
		gap = quiet ? 0 : pick_gap();
		if (gap != 0) begin
			evt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// wait for every owed status, then let the pipeline drain
	task automatic settle();
		evt_ch.valid <= 1'b0;
		do @(posedge clk); while (chk_owed != 0);
		repeat (4) @(posedge clk);
	endtask

	// leaves valid high so that back-to-back writes stay one beat each
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] d);
		cfg_t c;
		c.index = idx;
		c.data  = d;
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= c;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic program_regs(input logic [31:0] i, input logic [31:0] m,
			input logic [31:0] th);
		write_reg(REG_INITIAL_DELAY, i);
		write_reg(REG_MAX_DELAY, m);
		write_reg(REG_THRESHOLD, th);
		cfg_ch.valid <= 1'b0;
		init_w = i;
		max_w  = m;
		thr_w  = th[15:0];
	endtask

	task automatic step_tick();
		tick = tick + (($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 60));
	endtask

	// poll near where a retry is likely to fall due
	task automatic probe();
		logic [31:0] off;
		case ($urandom_range(0, 5))
			0: off = init_w;
			1: off = max_w;
			2: off = init_w << $urandom_range(1, 6);
			3: off = $urandom_range(0, 40);
			4: off = $urandom;
			default: off = max_w >> 1;
		endcase
		off = off + $urandom_range(0, 2) - 1;
		post_event(KIND_POLL, anchor + off, 1'($urandom));
	endtask

	task automatic outage_episode();
		int unsigned fails;
		int unsigned retries;
		int unsigned n;
		fails = (thr_w < 6) ? thr_w + $urandom_range(0, 2) : $urandom_range(1, 6);
		for (n = 0; n < fails; n++) begin
			step_tick();
			if ($urandom_range(0, 7) == 0) begin
				post_event(KIND_SERVICE, tick, 1'b1);
			end else begin
				anchor = tick;
				post_event(KIND_SERVICE, tick, 1'b0);
			end
		end
		repeat ($urandom_range(0, 2)) probe();
		retries = $urandom_range(0, 7);
		for (n = 0; n < retries; n++) begin
			step_tick();
			anchor = tick;
			post_event(KIND_REINIT, tick, 1'b0);
			repeat ($urandom_range(0, 2)) probe();
		end
		step_tick();
		case ($urandom_range(0, 5))
			0, 1, 2: post_event(KIND_REINIT, tick, 1'b1);
			3:       post_event(KIND_INITIAL, tick, 1'b1);
			4: begin
				anchor = tick;
				post_event(KIND_INITIAL, tick, 1'b0);
			end
			default: begin
			end
		endcase
	endtask

	task automatic noise_burst();
		repeat ($urandom_range(1, 8))
			post_event(kind_t'($urandom_range(0, 3)), $urandom, 1'($urandom));
	endtask

	task automatic wander(input int unsigned budget);
		int unsigned goal;
		goal = sent + budget;
		while (sent < goal) begin
			quiet = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 9) < 7)
				outage_episode();
			else
				noise_burst();
		end
		quiet = 1'b0;
	endtask

	initial begin
		logic [31:0] t0;
		int          i;
		arst_n       <= 1'b0;
		evt_ch.valid <= 1'b0;
		evt_ch.data  <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data  <= '0;
		init_w = InitialDelayRst;
		max_w  = MaxDelayRst;
		thr_w  = ThresholdRst;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings; the retry window straddles the tick wrap
		t0 = 32'hFFFF_FFC0;
		post_event(KIND_POLL, t0, 1'b1);
		post_event(KIND_INITIAL, t0, 1'b1);
		post_event(KIND_INITIAL, t0, 1'b0);
		post_event(KIND_POLL, t0 + 99, 1'b0);
		post_event(KIND_POLL, t0 + 100, 1'b1);
		post_event(KIND_POLL, t0 - 1, 1'b0);
		for (i = 0; i < 3; i++)
			post_event(KIND_SERVICE, t0 + i, 1'b0);
		post_event(KIND_SERVICE, t0 + 5, 1'b1);
		// climb the ladder up to the clamp and sit on it
		for (i = 0; i < 7; i++)
			post_event(KIND_REINIT, t0 + 200 + i, 1'b0);
		post_event(KIND_REINIT, t0 + 300, 1'b1);
		for (i = 0; i < 3; i++)
			post_event(KIND_SERVICE, t0 + 310 + i, 1'b0);
		post_event(KIND_INITIAL, t0 + 320, 1'b0);
		post_event(KIND_INITIAL, t0 + 330, 1'b1);
		post_event(KIND_POLL, 32'h0000_0000, 1'b0);
		tick = t0 + 400;
		anchor = tick;
		wander(160);

		// threshold of zero, tiny delays
		settle();
		write_reg(REG_UNUSED, $urandom);
		program_regs(32'd1, 32'd8, thr_word(16'd0));
		wander(180);

		// zero initial delay: the delay never grows
		settle();
		program_regs(32'd0, 32'hFFFF_FFFF, thr_word(16'd1));
		wander(160);

		// doubling would overflow 32 bits
		settle();
		program_regs(32'h8000_0001, 32'hFFFF_FFFF, thr_word(16'd2));
		wander(160);

		// maximum below initial
		settle();
		program_regs(32'd100, 32'd50, thr_word(16'd4));
		wander(160);

		// all ones: a long streak of failures never reaches the threshold
		settle();
		program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, thr_word(16'hFFFF));
		post_event(KIND_INITIAL, tick, 1'b1);
		quiet = 1'b1;
		for (i = 0; i < 40; i++)
			post_event(KIND_SERVICE, tick + i, 1'b0);
		post_event(KIND_POLL, tick, 1'b0);
		quiet = 1'b0;
		wander(120);

		repeat (3) begin
			settle();
			program_regs($urandom_range(1, 300), $urandom_range(0, 20000),
				thr_word(16'($urandom_range(0, 6))));
			wander(100);
		end

		settle();
		program_regs(32'hFFFF_FFFF, 32'd0, thr_word(16'd3));
		wander(80);

		settle();
		if (chk_mismatches == 0 && chk_owed == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/frb_pkg.sv
rtl/frb_if.sv
rtl/fault_recovery_backoff_top.sv
verif/fault_recovery_backoff_chk.sv
verif/fault_recovery_backoff_top_tb.sv
